// ===== src/triangle_box_overlap_test_unit_macros.svh =====
// Assertion macros shared by the triangle/box overlap test unit.
// No dependencies; included by the files that carry assertions.
`ifndef TRIANGLE_BOX_OVERLAP_TEST_UNIT_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TBOT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbot assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TBOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbot assertion failed");

`endif

// ===== src/tbot_pkg.sv =====
// Package for the triangle/box overlap test unit: default widths and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package tbot_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z   = 3'd5;

endpackage

// ===== src/triangle_box_overlap_test_unit.sv =====
// Throughput: one triangle per cycle while the output is not stalled by i_out_ready.
// Five register stages: offset/edges, products, differences/sums, axis compares, result.
// Each stage advances whenever its successor is empty or advancing, so bubbles collapse.
// Reset (synchronous, active low) empties the pipeline and clears the box registers to 0.
// Uses tbot_pkg and triangle_box_overlap_test_unit_macros.svh.
`timescale 1ns / 1ps
`include "triangle_box_overlap_test_unit_macros.svh"

module triangle_box_overlap_test_unit #(
    parameter int COORD_BITS = tbot_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbot_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [COORD_BITS-1:0]   i_vert0_x,
    input  logic signed [COORD_BITS-1:0]   i_vert0_y,
    input  logic signed [COORD_BITS-1:0]   i_vert0_z,
    input  logic signed [COORD_BITS-1:0]   i_vert1_x,
    input  logic signed [COORD_BITS-1:0]   i_vert1_y,
    input  logic signed [COORD_BITS-1:0]   i_vert1_z,
    input  logic signed [COORD_BITS-1:0]   i_vert2_x,
    input  logic signed [COORD_BITS-1:0]   i_vert2_y,
    input  logic signed [COORD_BITS-1:0]   i_vert2_z,
    input  logic signed [COORD_BITS-1:0]   i_normal_x,
    input  logic signed [COORD_BITS-1:0]   i_normal_y,
    input  logic signed [COORD_BITS-1:0]   i_normal_z,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_overlaps
);

    localparam int C    = COORD_BITS;
    localparam int VW   = C + 1;        // vertex offset, edge
    localparam int BW   = C + 2;        // box-axis compare
    localparam int MW   = 2 * C + 2;    // edge x vertex product
    localparam int PW   = 2 * C + 3;    // projection
    localparam int RAW  = 2 * C;        // |edge| x half
    localparam int RADW = 2 * C + 1;    // projected radius
    localparam int EW   = 2 * C + 4;    // edge-axis compare
    localparam int DW   = C + 2;        // corner minus vertex
    localparam int QW   = 2 * C + 2;    // plane product
    localparam int SW   = 2 * C + 4;    // plane sum

    localparam int NST  = 5;

    // configuration
    logic signed [C-1:0] r_ctr  [3];
    logic        [C-2:0] r_half [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_ctr[c]  <= '0;
                r_half[c] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbot_pkg::CFG_CENTER_X: r_ctr[0]  <= i_cfg_data;
                tbot_pkg::CFG_CENTER_Y: r_ctr[1]  <= i_cfg_data;
                tbot_pkg::CFG_CENTER_Z: r_ctr[2]  <= i_cfg_data;
                tbot_pkg::CFG_HALF_X:   r_half[0] <= i_cfg_data[C-2:0];
                tbot_pkg::CFG_HALF_Y:   r_half[1] <= i_cfg_data[C-2:0];
                tbot_pkg::CFG_HALF_Z:   r_half[2] <= i_cfg_data[C-2:0];
                default: ;
            endcase
        end
    end

    // stage flow control
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_out_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    logic signed [C-1:0] w_vert [3][3];
    logic signed [C-1:0] w_nrm  [3];

    assign w_vert[0][0] = i_vert0_x;
    assign w_vert[0][1] = i_vert0_y;
    assign w_vert[0][2] = i_vert0_z;
    assign w_vert[1][0] = i_vert1_x;
    assign w_vert[1][1] = i_vert1_y;
    assign w_vert[1][2] = i_vert1_z;
    assign w_vert[2][0] = i_vert2_x;
    assign w_vert[2][1] = i_vert2_y;
    assign w_vert[2][2] = i_vert2_z;
    assign w_nrm[0]     = i_normal_x;
    assign w_nrm[1]     = i_normal_y;
    assign w_nrm[2]     = i_normal_z;

    // stage 1: vertices relative to box center, edges
    logic signed [VW-1:0] r1_v [3][3];
    logic signed [VW-1:0] r1_e [3][3];
    logic signed [C-1:0]  r1_n [3];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_v[k][c] <= VW'(w_vert[k][c]) - VW'(r_ctr[c]);
                end
                r1_e[0][c] <= VW'(w_vert[1][c]) - VW'(w_vert[0][c]);
                r1_e[1][c] <= VW'(w_vert[2][c]) - VW'(w_vert[1][c]);
                r1_e[2][c] <= VW'(w_vert[0][c]) - VW'(w_vert[2][c]);
                r1_n[c]    <= w_nrm[c];
            end
        end
    end

    // stage 2: box-axis test, plane corner offsets, edge-axis products
    logic                  n2_boxsep;
    logic signed [DW-1:0]  n2_dn [3];
    logic signed [DW-1:0]  n2_df [3];

    always_comb begin
        logic signed [BW-1:0] lo;
        logic signed [BW-1:0] hi;
        logic signed [BW-1:0] hb;
        logic signed [DW-1:0] hd;
        logic signed [DW-1:0] v0;
        n2_boxsep = 1'b0;
        for (int c = 0; c < 3; c++) begin
            lo = BW'(r1_v[0][c]);
            hi = BW'(r1_v[0][c]);
            for (int k = 1; k < 3; k++) begin
                if (BW'(r1_v[k][c]) < lo) lo = BW'(r1_v[k][c]);
                if (BW'(r1_v[k][c]) > hi) hi = BW'(r1_v[k][c]);
            end
            hb = signed'({3'b000, r_half[c]});
            if (hb < lo || hi < -hb) n2_boxsep = 1'b1;
            // near and far box corners along the normal
            hd = signed'({3'b000, r_half[c]});
            v0 = DW'(r1_v[0][c]);
            if (r1_n[c] > 0) begin
                n2_dn[c] = -hd - v0;
                n2_df[c] = hd - v0;
            end else begin
                n2_dn[c] = hd - v0;
                n2_df[c] = -hd - v0;
            end
        end
    end

    logic                  r2_boxsep;
    logic signed [DW-1:0]  r2_dn [3];
    logic signed [DW-1:0]  r2_df [3];
    logic signed [C-1:0]   r2_n  [3];
    logic signed [MW-1:0]  r2_pa [3][3][3];
    logic signed [MW-1:0]  r2_pb [3][3][3];
    logic        [RAW-1:0] r2_ra [3][3];
    logic        [RAW-1:0] r2_rb [3][3];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_boxsep <= n2_boxsep;
            for (int c = 0; c < 3; c++) begin
                r2_dn[c] <= n2_dn[c];
                r2_df[c] <= n2_df[c];
                r2_n[c]  <= r1_n[c];
            end
        end
    end

    // edge k against box axis a uses the two other coordinates i and j
    for (genvar gk = 0; gk < 3; gk++) begin : g_edge
        for (genvar ga = 0; ga < 3; ga++) begin : g_axis
            localparam int I = (ga + 1) % 3;
            localparam int J = (ga + 2) % 3;
            logic [VW-1:0] w_abs_i;
            logic [VW-1:0] w_abs_j;

            assign w_abs_i = r1_e[gk][I][VW-1] ? VW'(-r1_e[gk][I]) : VW'(r1_e[gk][I]);
            assign w_abs_j = r1_e[gk][J][VW-1] ? VW'(-r1_e[gk][J]) : VW'(r1_e[gk][J]);

            always_ff @(posedge i_clk) begin
                if (w_en[1]) begin
                    for (int t = 0; t < 3; t++) begin
                        r2_pa[gk][ga][t] <= MW'(r1_e[gk][J]) * MW'(r1_v[t][I]);
                        r2_pb[gk][ga][t] <= MW'(r1_e[gk][I]) * MW'(r1_v[t][J]);
                    end
                    r2_ra[gk][ga] <= RAW'(w_abs_j) * RAW'(r_half[I]);
                    r2_rb[gk][ga] <= RAW'(w_abs_i) * RAW'(r_half[J]);
                end
            end
        end
    end

    // stage 3: projections, radii, plane products
    logic                   r3_boxsep;
    logic signed [PW-1:0]   r3_p   [3][3][3];
    logic        [RADW-1:0] r3_rad [3][3];
    logic signed [QW-1:0]   r3_qn  [3];
    logic signed [QW-1:0]   r3_qf  [3];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_boxsep <= r2_boxsep;
            for (int c = 0; c < 3; c++) begin
                r3_qn[c] <= QW'(r2_n[c]) * QW'(r2_dn[c]);
                r3_qf[c] <= QW'(r2_n[c]) * QW'(r2_df[c]);
            end
            for (int k = 0; k < 3; k++) begin
                for (int a = 0; a < 3; a++) begin
                    for (int t = 0; t < 3; t++) begin
                        r3_p[k][a][t] <= PW'(r2_pa[k][a][t]) - PW'(r2_pb[k][a][t]);
                    end
                    r3_rad[k][a] <= RADW'(r2_ra[k][a]) + RADW'(r2_rb[k][a]);
                end
            end
        end
    end

    // stage 4: edge-axis span compares, plane sums
    logic n4_edgesep;
    logic n4_planesep;

    always_comb begin
        logic signed [EW-1:0] lo;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] rs;
        logic signed [SW-1:0] smin;
        logic signed [SW-1:0] smax;
        n4_edgesep = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                lo = EW'(r3_p[k][a][0]);
                hi = EW'(r3_p[k][a][0]);
                for (int t = 1; t < 3; t++) begin
                    if (EW'(r3_p[k][a][t]) < lo) lo = EW'(r3_p[k][a][t]);
                    if (EW'(r3_p[k][a][t]) > hi) hi = EW'(r3_p[k][a][t]);
                end
                rs = signed'({3'b000, r3_rad[k][a]});
                if (rs < lo || hi < -rs) n4_edgesep = 1'b1;
            end
        end
        smin = SW'(r3_qn[0]) + SW'(r3_qn[1]) + SW'(r3_qn[2]);
        smax = SW'(r3_qf[0]) + SW'(r3_qf[1]) + SW'(r3_qf[2]);
        n4_planesep = (smin > 0) || smax[SW-1];
    end

    logic r4_boxsep;
    logic r4_edgesep;
    logic r4_planesep;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_boxsep   <= r3_boxsep;
            r4_edgesep  <= n4_edgesep;
            r4_planesep <= n4_planesep;
        end
    end

    // stage 5: result register
    logic r5_overlaps;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_overlaps <= !(r4_boxsep || r4_edgesep || r4_planesep);
        end
    end

    assign o_overlaps = r5_overlaps;

    // an empty first stage always takes a transaction
    `TBOT_ASSERT_NOW(a_empty_takes, i_clk, i_rst_n, !r_vld[0], o_in_ready)
    // a new result only ever comes out of the compare stage
    `TBOT_ASSERT_NOW(a_out_from_s4, i_clk, i_rst_n, $rose(o_out_valid), $past(r_vld[3]))
    // a stalled full stage keeps its item
    `TBOT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_vld[3] && !w_en[3], r_vld[3])
    // an accepted transaction occupies stage one next cycle
    `TBOT_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])

endmodule
